### sv/nfa_pkg.sv
// Shared types, widths and command codes for the next-fit free-list allocator.
package nfa_pkg;

  localparam int ADDR_W           = 32;
  localparam int BYTES_W          = 24;
  localparam int UNITS_W          = 22;
  localparam int NEED_W           = BYTES_W + 1;
  localparam int STATUS_W         = 2;
  localparam int CFG_IDX_W        = 1;
  localparam int CFG_DATA_W       = 32;
  localparam int UNIT_BYTES_DEF   = 8;
  localparam int MAX_EXTENTS_DEF  = 64;
  localparam logic [UNITS_W-1:0] UNITS_MAX = {UNITS_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_REGION_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_BYTES = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FIT  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0]  start;
    logic [UNITS_W-1:0] units;
  } ext_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_A_INIT,
    OP_RD_POS,
    OP_A_NEXT,
    OP_A_HIT,
    OP_A_EXACT,
    OP_A_TAIL,
    OP_A_ADDR,
    OP_ROVER_BEFORE,
    OP_RM_RD,
    OP_RM_WR,
    OP_RM_END,
    OP_F_INIT,
    OP_F_CUR,
    OP_F_ADV,
    OP_F_EVNEXT,
    OP_F_EVPREV,
    OP_F_WPREV,
    OP_F_WCUR,
    OP_INS_INIT,
    OP_INS_RD,
    OP_INS_WR,
    OP_INS_PUT,
    OP_FINISH
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [STATUS_W-1:0] code;
  } cmd_t;

  typedef struct packed {
    logic action;
    logic bytes_zero;
    logic early_fail;
    logic uaddr_zero;
    logic units_zero;
    logic hit;
    logic exact;
    logic scan_last;
    logic rm_last;
    logic pos_end;
    logic start_ge;
    logic mnext;
    logic mprev;
    logic full;
    logic ins_done;
    logic out_busy;
  } sts_t;

endpackage

### sv/nfa_if.sv
// Request and result channel interfaces of the allocator.
interface nfa_in_if import nfa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               action;
  logic [BYTES_W-1:0] byte_count;
  logic [ADDR_W-1:0]  block_address;
  logic [UNITS_W-1:0] block_units;

  modport source (output valid, action, byte_count, block_address, block_units,
                  input ready);
  modport sink (input valid, action, byte_count, block_address, block_units,
                output ready);
endinterface

interface nfa_out_if import nfa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   user_address;
  logic [UNITS_W-1:0]  granted_units;

  modport source (output valid, status, user_address, granted_units, input ready);
  modport sink (input valid, status, user_address, granted_units, output ready);
endinterface

### sv/nfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module nfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/nfa_dp.sv
// Datapath: region registers, extent table memory, scan pointers and result register.
module nfa_dp import nfa_pkg::*; #(
  parameter int UNIT_BYTES  = UNIT_BYTES_DEF,
  parameter int MAX_EXTENTS = MAX_EXTENTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_action,
  input  logic [BYTES_W-1:0]    in_byte_count,
  input  logic [ADDR_W-1:0]     in_block_address,
  input  logic [UNITS_W-1:0]    in_block_units,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [STATUS_W-1:0]   out_status,
  output logic [ADDR_W-1:0]     out_user_address,
  output logic [UNITS_W-1:0]    out_granted_units
);

  localparam int IW = $clog2(MAX_EXTENTS);
  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam int SH = $clog2(UNIT_BYTES);

  logic [ADDR_W-1:0]   region_start_r;
  logic [BYTES_W-1:0]  region_bytes_r;
  logic [CW-1:0]       count_r;
  logic [IW-1:0]       rover_r;
  logic [CW-1:0]       pos_r;
  logic [CW-1:0]       p_r;
  logic [CW-1:0]       t_r;
  logic                action_r;
  logic [BYTES_W-1:0]  bytes_r;
  logic [ADDR_W-1:0]   uaddr_r;
  logic [ADDR_W-1:0]   hdr_r;
  logic [UNITS_W-1:0]  units_r;
  logic [NEED_W-1:0]   need_r;
  logic [UNITS_W-1:0]  total_r;
  logic                mnext_r;
  logic                mprev_r;
  ext_t                cur_r;
  ext_t                prev_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [UNITS_W-1:0]  granted_r;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [ADDR_W-1:0]   out_addr_r;
  logic [UNITS_W-1:0]  out_granted_r;

  logic                ram_we;
  logic [IW-1:0]       ram_waddr;
  ext_t                ram_wdata;
  logic [IW-1:0]       ram_raddr;
  ext_t                rd;

  logic [NEED_W-1:0]   need_w;
  logic [BYTES_W-1:0]  cfg_bytes;
  logic [ADDR_W-1:0]   cfg_start;
  logic [UNITS_W-1:0]  cfg_units;
  logic [CW-1:0]       rov_n;
  logic [CW-1:0]       rov_inc;
  logic [CW-1:0]       pos_inc;
  logic [UNITS_W:0]    sum_next;
  logic [UNITS_W:0]    sum_prev;
  logic [ADDR_W:0]     end_w;
  logic [ADDR_W:0]     prev_end;
  logic [UNITS_W-1:0]  tail_units;

  function automatic logic [IW-1:0] before_f(input logic [CW-1:0] k,
                                             input logic [CW-1:0] cnt);
    logic [CW-1:0] r;
    if (cnt == '0) begin
      r = '0;
    end else if (k == '0) begin
      r = cnt - CW'(1);
    end else begin
      r = k - CW'(1);
    end
    return r[IW-1:0];
  endfunction

  nfa_ram #(
    .WIDTH ($bits(ext_t)),
    .DEPTH (MAX_EXTENTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd)
  );

  always_comb begin
    need_w     = ((NEED_W'(in_byte_count) + NEED_W'(UNIT_BYTES - 1)) >> SH) + NEED_W'(1);
    cfg_start  = (cfg_index == REG_REGION_START) ? cfg_wdata : region_start_r;
    cfg_bytes  = (cfg_index == REG_REGION_BYTES) ? cfg_wdata[BYTES_W-1:0] : region_bytes_r;
    cfg_units  = UNITS_W'(cfg_bytes >> SH);
    rov_n      = (CW'(rover_r) >= count_r) ? '0 : CW'(rover_r);
    rov_inc    = rov_n + CW'(1);
    pos_inc    = pos_r + CW'(1);
    sum_next   = (UNITS_W+1)'(units_r) + (UNITS_W+1)'(cur_r.units);
    sum_prev   = (UNITS_W+1)'(total_r) + (UNITS_W+1)'(prev_r.units);
    end_w      = (ADDR_W+1)'(hdr_r) + ((ADDR_W+1)'(units_r) << SH);
    prev_end   = (ADDR_W+1)'(prev_r.start) + ((ADDR_W+1)'(prev_r.units) << SH);
    tail_units = cur_r.units - need_r[UNITS_W-1:0];
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos_r[IW-1:0];
    ram_wdata = rd;
    ram_raddr = pos_r[IW-1:0];
    if (cfg_we) begin
      ram_we          = 1'b1;
      ram_waddr       = '0;
      ram_wdata.start = cfg_start;
      ram_wdata.units = cfg_units;
    end else begin
      case (cmd.op)
        OP_A_TAIL: begin
          ram_we          = 1'b1;
          ram_wdata.start = cur_r.start;
          ram_wdata.units = tail_units;
        end
        OP_RM_RD: begin
          ram_raddr = IW'(p_r + CW'(1));
        end
        OP_RM_WR, OP_INS_WR: begin
          ram_we    = 1'b1;
          ram_waddr = p_r[IW-1:0];
        end
        OP_INS_RD: begin
          ram_raddr = IW'(p_r - CW'(1));
        end
        OP_F_WPREV: begin
          ram_we          = 1'b1;
          ram_waddr       = IW'(pos_r - CW'(1));
          ram_wdata.start = prev_r.start;
          ram_wdata.units = UNITS_W'(sum_prev);
        end
        OP_F_WCUR: begin
          ram_we          = 1'b1;
          ram_wdata.start = hdr_r;
          ram_wdata.units = total_r;
        end
        OP_INS_PUT: begin
          ram_we          = 1'b1;
          ram_wdata.start = hdr_r;
          ram_wdata.units = units_r;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_start_r <= '0;
      region_bytes_r <= '0;
      count_r        <= '0;
      rover_r        <= '0;
      out_valid_r    <= 1'b0;
    end else if (cfg_we) begin
      region_start_r <= cfg_start;
      region_bytes_r <= cfg_bytes;
      count_r        <= (cfg_units != '0) ? CW'(1) : '0;
      rover_r        <= '0;
    end else begin
      if (out_valid_r && out_ready && (cmd.op != OP_FINISH)) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        OP_LOAD: begin
          action_r  <= in_action;
          bytes_r   <= in_byte_count;
          uaddr_r   <= in_block_address;
          hdr_r     <= in_block_address - ADDR_W'(UNIT_BYTES);
          units_r   <= in_block_units;
          need_r    <= need_w;
          addr_r    <= '0;
          granted_r <= '0;
        end
        OP_A_INIT: begin
          rover_r <= rov_n[IW-1:0];
          pos_r   <= (rov_inc == count_r) ? '0 : rov_inc;
          t_r     <= CW'(1);
        end
        OP_A_NEXT: begin
          pos_r <= (pos_inc == count_r) ? '0 : pos_inc;
          t_r   <= t_r + CW'(1);
        end
        OP_A_HIT: begin
          cur_r     <= rd;
          granted_r <= need_r[UNITS_W-1:0];
        end
        OP_A_EXACT: begin
          addr_r <= cur_r.start + ADDR_W'(UNIT_BYTES);
          p_r    <= pos_r;
        end
        OP_A_TAIL: begin
          cur_r.units <= tail_units;
        end
        OP_A_ADDR: begin
          addr_r  <= cur_r.start + (ADDR_W'(cur_r.units) << SH) + ADDR_W'(UNIT_BYTES);
          rover_r <= before_f(pos_r, count_r);
        end
        OP_ROVER_BEFORE: begin
          rover_r <= before_f(pos_r, count_r);
        end
        OP_RM_WR: begin
          p_r <= p_r + CW'(1);
        end
        OP_RM_END: begin
          count_r <= count_r - CW'(1);
        end
        OP_F_INIT: begin
          pos_r <= '0;
        end
        OP_F_CUR: begin
          cur_r <= rd;
        end
        OP_F_ADV: begin
          prev_r <= rd;
          pos_r  <= pos_inc;
        end
        OP_F_EVNEXT: begin
          if ((pos_r != count_r) && (end_w == (ADDR_W+1)'(cur_r.start)) &&
              (sum_next <= (UNITS_W+1)'(UNITS_MAX))) begin
            mnext_r <= 1'b1;
            total_r <= UNITS_W'(sum_next);
          end else begin
            mnext_r <= 1'b0;
            total_r <= units_r;
          end
        end
        OP_F_EVPREV: begin
          mprev_r <= (pos_r != '0) && (prev_end == (ADDR_W+1)'(hdr_r)) &&
                     (sum_prev <= (UNITS_W+1)'(UNITS_MAX));
        end
        OP_F_WPREV: begin
          rover_r <= IW'(pos_r - CW'(1));
          p_r     <= pos_r;
        end
        OP_F_WCUR: begin
          rover_r <= before_f(pos_r, count_r);
        end
        OP_INS_INIT: begin
          p_r <= count_r;
        end
        OP_INS_WR: begin
          p_r <= p_r - CW'(1);
        end
        OP_INS_PUT: begin
          count_r <= count_r + CW'(1);
        end
        OP_FINISH: begin
          out_valid_r   <= 1'b1;
          out_status_r  <= cmd.code;
          out_addr_r    <= addr_r;
          out_granted_r <= granted_r;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    sts.action     = action_r;
    sts.bytes_zero = (bytes_r == '0);
    sts.early_fail = (count_r == '0) || (need_r > NEED_W'(UNITS_MAX));
    sts.uaddr_zero = (uaddr_r == '0);
    sts.units_zero = (units_r == '0);
    sts.hit        = (NEED_W'(rd.units) >= need_r);
    sts.exact      = (cur_r.units == need_r[UNITS_W-1:0]);
    sts.scan_last  = (t_r == count_r);
    sts.rm_last    = ((p_r + CW'(1)) >= count_r);
    sts.pos_end    = (pos_r == count_r);
    sts.start_ge   = (rd.start >= hdr_r);
    sts.mnext      = mnext_r;
    sts.mprev      = mprev_r;
    sts.full       = (count_r >= CW'(MAX_EXTENTS));
    sts.ins_done   = (p_r == pos_r);
    sts.out_busy   = out_valid_r && !out_ready;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_user_address  = out_addr_r;
  assign out_granted_units = out_granted_r;

endmodule

### sv/nfa_ctrl.sv
// Controller state machine sequencing allocate and free requests over the datapath.
module nfa_ctrl import nfa_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_A_RD,
    S_A_CMP,
    S_A_TAKE,
    S_A_TAIL2,
    S_RM_CHK,
    S_RM_WR,
    S_RM_POST,
    S_F_CHK,
    S_F_CMP,
    S_F_EVN,
    S_F_EVP,
    S_F_ACT,
    S_I_CHK,
    S_I_WR,
    S_I_POST,
    S_FIN
  } state_t;

  state_t              state_r, state_nxt;
  logic [STATUS_W-1:0] code_r, code_nxt;
  op_t                 op;

  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    op        = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op        = OP_LOAD;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_nxt = S_FIN;
        if (!sts.action) begin
          if (sts.bytes_zero) begin
            code_nxt = ST_ZERO;
          end else if (sts.early_fail) begin
            code_nxt = ST_NO_FIT;
          end else begin
            op        = OP_A_INIT;
            state_nxt = S_A_RD;
          end
        end else begin
          if (sts.uaddr_zero) begin
            code_nxt = ST_OK;
          end else if (sts.units_zero) begin
            code_nxt = ST_ZERO;
          end else begin
            op        = OP_F_INIT;
            state_nxt = S_F_CHK;
          end
        end
      end
      S_A_RD: begin
        op        = OP_RD_POS;
        state_nxt = S_A_CMP;
      end
      S_A_CMP: begin
        if (sts.hit) begin
          op        = OP_A_HIT;
          state_nxt = S_A_TAKE;
        end else if (sts.scan_last) begin
          code_nxt  = ST_NO_FIT;
          state_nxt = S_FIN;
        end else begin
          op        = OP_A_NEXT;
          state_nxt = S_A_RD;
        end
      end
      S_A_TAKE: begin
        code_nxt = ST_OK;
        if (sts.exact) begin
          op        = OP_A_EXACT;
          state_nxt = S_RM_CHK;
        end else begin
          op        = OP_A_TAIL;
          state_nxt = S_A_TAIL2;
        end
      end
      S_A_TAIL2: begin
        op        = OP_A_ADDR;
        state_nxt = S_FIN;
      end
      S_RM_CHK: begin
        if (sts.rm_last) begin
          op        = OP_RM_END;
          state_nxt = S_RM_POST;
        end else begin
          op        = OP_RM_RD;
          state_nxt = S_RM_WR;
        end
      end
      S_RM_WR: begin
        op        = OP_RM_WR;
        state_nxt = S_RM_CHK;
      end
      S_RM_POST: begin
        if (!sts.action) begin
          op = OP_ROVER_BEFORE;
        end
        state_nxt = S_FIN;
      end
      S_F_CHK: begin
        if (sts.pos_end) begin
          state_nxt = S_F_EVN;
        end else begin
          op        = OP_RD_POS;
          state_nxt = S_F_CMP;
        end
      end
      S_F_CMP: begin
        if (sts.start_ge) begin
          op        = OP_F_CUR;
          state_nxt = S_F_EVN;
        end else begin
          op        = OP_F_ADV;
          state_nxt = S_F_CHK;
        end
      end
      S_F_EVN: begin
        op        = OP_F_EVNEXT;
        state_nxt = S_F_EVP;
      end
      S_F_EVP: begin
        op        = OP_F_EVPREV;
        state_nxt = S_F_ACT;
      end
      S_F_ACT: begin
        code_nxt = ST_OK;
        if (sts.mprev) begin
          op        = OP_F_WPREV;
          state_nxt = sts.mnext ? S_RM_CHK : S_FIN;
        end else if (sts.mnext) begin
          op        = OP_F_WCUR;
          state_nxt = S_FIN;
        end else if (sts.full) begin
          code_nxt  = ST_FULL;
          state_nxt = S_FIN;
        end else begin
          op        = OP_INS_INIT;
          state_nxt = S_I_CHK;
        end
      end
      S_I_CHK: begin
        if (sts.ins_done) begin
          op        = OP_INS_PUT;
          state_nxt = S_I_POST;
        end else begin
          op        = OP_INS_RD;
          state_nxt = S_I_WR;
        end
      end
      S_I_WR: begin
        op        = OP_INS_WR;
        state_nxt = S_I_CHK;
      end
      S_I_POST: begin
        op        = OP_ROVER_BEFORE;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          op        = OP_FINISH;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      code_r  <= ST_OK;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign cmd.op   = op;
  assign cmd.code = code_r;

endmodule

### sv/next_fit_free_list_allocator.sv
// Top level: next-fit free-list allocator over an address-sorted extent table.
// Allocate: rejected early, or a next-fit scan from the extent after the rover; a tail fit
// trims the extent, an exact fit removes it and shifts later entries down. Free: ignored, or
// a search past the extents below the block, then a merge or an insert shifting entries up.
// One request at a time; the next can be accepted in the same cycle as the result beat is
// raised. Synchronous active-low reset empties the table and zeroes the rover.
module next_fit_free_list_allocator import nfa_pkg::*; #(
  parameter int UNIT_BYTES  = UNIT_BYTES_DEF,
  parameter int MAX_EXTENTS = MAX_EXTENTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  nfa_in_if.sink                in_ch,
  nfa_out_if.source             out_ch
);

  cmd_t cmd;
  sts_t sts;

  nfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  nfa_dp #(
    .UNIT_BYTES  (UNIT_BYTES),
    .MAX_EXTENTS (MAX_EXTENTS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_action         (in_ch.action),
    .in_byte_count     (in_ch.byte_count),
    .in_block_address  (in_ch.block_address),
    .in_block_units    (in_ch.block_units),
    .cmd               (cmd),
    .sts               (sts),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_status        (out_ch.status),
    .out_user_address  (out_ch.user_address),
    .out_granted_units (out_ch.granted_units)
  );

endmodule

### tb/tb_if.sv
// Testbench package holding the expected result record.
package tb_alloc_pkg;
  import nfa_pkg::*;
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   user_address;
    logic [UNITS_W-1:0]  granted_units;
  } grant_t;
endpackage

### tb/tb.sv
// Self-checking testbench for the next-fit free-list allocator with its own heap predictor.
module tb;
  import nfa_pkg::*;
  import tb_alloc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int UB = 8;
  localparam int MAXE = 64;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  nfa_in_if in_ch ();
  nfa_out_if out_ch ();

  next_fit_free_list_allocator #(.UNIT_BYTES(UB), .MAX_EXTENTS(MAXE)) DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = 1'b0;
    in_ch.byte_count = '0;
    in_ch.block_address = '0;
    in_ch.block_units = '0;
    out_ch.ready = 1'b0;
  end

  // Predictor state.
  logic [31:0] heap_base;
  logic [23:0] heap_len;
  logic [31:0] ext_lo [MAXE];
  logic [21:0] ext_sz [MAXE];
  int ext_n;
  int rover;
  grant_t pending_grants[$];
  int errors = 0;
  bit stall_en = 1'b1;

  // Live allocations, kept so that most frees return real blocks.
  logic [31:0] live_addr[$];
  logic [21:0] live_units[$];

  function automatic void heap_rebuild();
    rover = 0;
    ext_n = 0;
    if (heap_len / UB != 0) begin
      ext_lo[0] = heap_base;
      ext_sz[0] = 22'(heap_len / UB);
      ext_n = 1;
    end
  endfunction

  function automatic void ext_remove(int k);
    for (int i = k; i < ext_n - 1; i++) begin
      ext_lo[i] = ext_lo[i+1];
      ext_sz[i] = ext_sz[i+1];
    end
    ext_n--;
  endfunction

  function automatic int ext_prior(int k);
    if (ext_n == 0) return 0;
    return (k == 0) ? ext_n - 1 : k - 1;
  endfunction

  function automatic grant_t heap_alloc(logic [23:0] nbytes);
    grant_t g;
    longint need;
    longint hdr;
    int j;
    g = '0;
    if (nbytes == 0) begin
      g.status = ST_ZERO;
      return g;
    end
    need = (longint'(nbytes) + UB - 1) / UB + 1;
    g.status = ST_NO_FIT;
    if (ext_n == 0 || need > longint'(UNITS_MAX)) return g;
    if (rover >= ext_n) rover = 0;
    for (int t = 1; t <= ext_n; t++) begin
      j = (rover + t) % ext_n;
      if (longint'(ext_sz[j]) >= need) begin
        if (longint'(ext_sz[j]) == need) begin
          hdr = longint'(ext_lo[j]);
          ext_remove(j);
        end else begin
          ext_sz[j] = ext_sz[j] - need[21:0];
          hdr = longint'(ext_lo[j]) + longint'(ext_sz[j]) * UB;
        end
        rover = ext_prior(j);
        g.status = ST_OK;
        g.user_address = hdr[31:0] + UB;
        g.granted_units = need[21:0];
        return g;
      end
    end
    return g;
  endfunction

  function automatic grant_t heap_free(logic [31:0] uaddr, logic [21:0] units);
    grant_t g;
    longint hdr;
    longint fin;
    longint total;
    int k;
    bit mn;
    bit mp;
    g = '0;
    k = 0;
    mn = 0;
    mp = 0;
    if (uaddr == 0) return g;
    if (units == 0) begin
      g.status = ST_ZERO;
      return g;
    end
    hdr = longint'(uaddr - 32'(UB));
    while (k < ext_n && longint'(ext_lo[k]) < hdr) k++;
    fin = hdr + longint'(units) * UB;
    total = longint'(units);
    if (k < ext_n && fin == longint'(ext_lo[k]) &&
        total + ext_sz[k] <= longint'(UNITS_MAX)) begin
      mn = 1;
      total += ext_sz[k];
    end
    if (k > 0 && longint'(ext_lo[k-1]) + longint'(ext_sz[k-1]) * UB == hdr &&
        total + ext_sz[k-1] <= longint'(UNITS_MAX))
      mp = 1;
    if (mp) begin
      ext_sz[k-1] = ext_sz[k-1] + total[21:0];
      if (mn) ext_remove(k);
      rover = k - 1;
    end else if (mn) begin
      ext_lo[k] = hdr[31:0];
      ext_sz[k] = total[21:0];
      rover = ext_prior(k);
    end else begin
      if (ext_n >= MAXE) begin
        g.status = ST_FULL;
        return g;
      end
      for (int i = ext_n; i > k; i--) begin
        ext_lo[i] = ext_lo[i-1];
        ext_sz[i] = ext_sz[i-1];
      end
      ext_lo[k] = hdr[31:0];
      ext_sz[k] = units;
      ext_n++;
      rover = ext_prior(k);
    end
    return g;
  endfunction

  function automatic int rand_gap();
    if (!stall_en) return 0;
    if ($urandom_range(0, 3) != 0) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  task automatic send_request(bit act, logic [23:0] nbytes, logic [31:0] uaddr,
                              logic [21:0] units);
    grant_t g;
    repeat (rand_gap() + 1) @(posedge clk);
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.byte_count <= nbytes;
    in_ch.block_address <= uaddr;
    in_ch.block_units <= units;
    do @(posedge clk); while (!in_ch.ready);
    in_ch.valid <= 1'b0;
    g = act ? heap_free(uaddr, units) : heap_alloc(nbytes);
    if (!act && g.status == ST_OK) begin
      live_addr.push_back(g.user_address);
      live_units.push_back(g.granted_units);
    end
    pending_grants.push_back(g);
  endtask

  task automatic drain();
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == REG_REGION_START) heap_base = val;
    else heap_len = val[23:0];
    heap_rebuild();
    live_addr.delete();
    live_units.delete();
  endtask

  task automatic set_region(logic [31:0] base, logic [23:0] len);
    drain();
    write_reg(REG_REGION_START, base);
    write_reg(REG_REGION_BYTES, {8'd0, len});
    cfg_we <= 1'b0;
  endtask

  task automatic free_live(int idx);
    logic [31:0] a;
    logic [21:0] u;
    a = live_addr[idx];
    u = live_units[idx];
    live_addr.delete(idx);
    live_units.delete(idx);
    send_request(1'b1, '0, a, u);
  endtask

  always @(posedge clk) begin
    grant_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_grants.size() == 0) begin
        $display("%0t: unexpected beat status=%0d addr=%h units=%0d", $time,
                 out_ch.status, out_ch.user_address, out_ch.granted_units);
        errors++;
      end else begin
        e = pending_grants.pop_front();
        if (out_ch.status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, out_ch.status);
          errors++;
        end
        if (out_ch.user_address !== e.user_address) begin
          $display("%0t: user_address expected %h actual %h", $time, e.user_address,
                   out_ch.user_address);
          errors++;
        end
        if (out_ch.granted_units !== e.granted_units) begin
          $display("%0t: granted_units expected %0d actual %0d", $time, e.granted_units,
                   out_ch.granted_units);
          errors++;
        end
      end
    end
    out_ch.ready <= (stall_en && $urandom_range(0, 4) == 0) ? 1'b0 : 1'b1;
  end

  task automatic test_directed();
    set_region(32'h0000_1000, 24'd4096);
    send_request(1'b0, 24'd0, '0, '0);
    send_request(1'b0, 24'hFF_FFFF, '0, '0);
    send_request(1'b0, 24'd1, '0, '0);
    send_request(1'b0, 24'd8, '0, '0);
    send_request(1'b0, 24'd9, '0, '0);
    send_request(1'b1, '0, 32'd0, 22'd3);
    send_request(1'b1, '0, 32'h0000_2000, 22'd0);
    free_live(1);
    free_live(0);
    send_request(1'b1, '0, 32'hFFFF_FFF8, 22'h3F_FFFF);
    send_request(1'b1, '0, 32'h0000_0004, 22'd1);
    send_request(1'b1, '0, 32'h8000_0008, 22'h3F_FFFF);
    send_request(1'b1, '0, 32'h8000_0008, 22'd2);
    send_request(1'b0, 24'd4000, '0, '0);
    send_request(1'b0, 24'd16, '0, '0);
    set_region(32'hFFFF_FF00, 24'hFF_FFFF);
    send_request(1'b0, 24'd100, '0, '0);
    free_live(0);
    set_region(32'd0, 24'd7);
    send_request(1'b0, 24'd1, '0, '0);
    send_request(1'b1, '0, 32'd16, 22'd1);
    send_request(1'b0, 24'd1, '0, '0);
  endtask

  // Fills the table with scattered frees until it reports full.
  task automatic test_table_full();
    set_region(32'h0010_0000, 24'd64);
    for (int i = 0; i < MAXE + 4; i++)
      send_request(1'b1, '0, 32'h0020_0008 + i * 64, 22'd2);
    send_request(1'b0, 24'd8, '0, '0);
  endtask

  task automatic test_random();
    int idx;
    int r;
    for (int i = 0; i < 1300; i++) begin
      if (i % 260 == 0)
        set_region($urandom,
                   24'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(64, 8192)));
      if (i == 650) begin
        stall_en = 1'b0;
        drain();
      end
      if (i == 800) stall_en = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 45)
        send_request(1'b0, 24'(r < 2 ? $urandom : $urandom_range(0, 300)), '0, '0);
      else if (r < 88 && live_addr.size() != 0) begin
        idx = $urandom_range(0, live_addr.size() - 1);
        free_live(idx);
      end else
        send_request(1'b1, '0, $urandom, 22'(r < 94 ? $urandom : $urandom_range(0, 40)));
    end
    drain();
  endtask

  initial begin
    heap_base = '0;
    heap_len = '0;
    heap_rebuild();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_table_full();
    test_random();
    if (errors == 0 && pending_grants.size() == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: done, errors");
    $finish;
  end
endmodule
